// ===== rtl/core/hsv_palette_group_classifier_assert.svh =====
// Assertion macros used by the classifier controller.
`ifndef HSV_PALETTE_GROUP_CLASSIFIER_ASSERT_SVH
`define HSV_PALETTE_GROUP_CLASSIFIER_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define HPGC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define HPGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/hpgc_pkg.sv =====
package hpgc_pkg;

	localparam int TABLE_GROUPS = 12;
	localparam int SCORE_DEN = 459000;
	// floor(n * 65536 / 459000) is (n * SCORE_RECIP) >> SCORE_SHIFT, exact for n <= 459000.
	localparam logic [32:0] SCORE_RECIP = 33'd4905881948;
	localparam int SCORE_SHIFT = 35;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [23:0] SUM_MAX = 24'hFFFFFF;
	localparam logic [19:0] WT_MAX = 20'hFFFFF;
	localparam logic [15:0] CNT_MAX = 16'hFFFF;
	localparam logic [3:0] MISC_GROUP = 4'd0;

	typedef struct packed {
		logic [11:0] hue_tenths;
		logic [7:0] saturation;
		logic [7:0] brightness;
		logic [16:0] weight;
		logic last_color;
	} in_item_t;

	typedef struct packed {
		logic [3:0] group_index;
		logic [16:0] group_score;
		logic [15:0] group_tally;
	} out_item_t;

	typedef struct packed {
		logic [11:0] hlo;
		logic [11:0] hhi;
		logic [6:0] slo;
		logic [6:0] shi;
		logic [6:0] vlo;
		logic [6:0] vhi;
	} hsv_range_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;        // capture the input item
		logic score;       // compute per-group score numerators
		logic norm;        // turn numerators into Q16 color scores
		logic accum;       // add weighted scores into the sums
		logic div_start;   // start dividing one group sum
		logic [3:0] grp;   // group under division
		logic div_step;    // one quotient bit
		logic pick;        // compare quotient with best
		logic finish;      // threshold, tally, clear
	} dp_cmd_t;

	typedef struct packed {
		logic last;
		logic counted;     // color within MAX_COLORS
		logic div_done;
	} dp_sts_t;

	function automatic hsv_range_t range_of(input logic [3:0] g);
		hsv_range_t r;
		case (g)
			4'd0: r = '{12'd2000, 12'd2600, 7'd30, 7'd100, 7'd30, 7'd100};
			4'd1: r = '{12'd3400, 12'd200, 7'd30, 7'd100, 7'd30, 7'd100};
			4'd2: r = '{12'd800, 12'd1400, 7'd30, 7'd100, 7'd30, 7'd100};
			4'd3: r = '{12'd200, 12'd500, 7'd40, 7'd100, 7'd40, 7'd100};
			4'd4: r = '{12'd2600, 12'd3000, 7'd30, 7'd100, 7'd30, 7'd100};
			4'd5: r = '{12'd500, 12'd800, 7'd40, 7'd100, 7'd50, 7'd100};
			4'd6: r = '{12'd3000, 12'd3400, 7'd30, 7'd100, 7'd40, 7'd100};
			4'd7: r = '{12'd1600, 12'd2000, 7'd40, 7'd100, 7'd40, 7'd100};
			4'd8: r = '{12'd0, 12'd3600, 7'd0, 7'd100, 7'd0, 7'd25};
			4'd9: r = '{12'd0, 12'd3600, 7'd0, 7'd30, 7'd80, 7'd100};
			4'd10: r = '{12'd0, 12'd3600, 7'd0, 7'd15, 7'd25, 7'd80};
			4'd11: r = '{12'd250, 12'd450, 7'd20, 7'd70, 7'd30, 7'd70};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/hsv_palette_group_classifier.sv =====
// Sequence: an accepted color is scored and, if it is within the color limit, normalized and
// accumulated before the next accept; a color past the color limit is only scored. For a last
// color each active group sum is then divided in turn by the one-bit-per-cycle divider shared
// by all groups for the normalization, and the result item is valid once all are picked.
// Throughput: one item is worked on at a time; the next is taken as the result is taken.
// Reset (arst_n low, asynchronous) clears sums, weight total, tallies and sets the
// threshold to 19661.
module hsv_palette_group_classifier #(
	parameter int NUM_GROUPS = 12,
	parameter int MAX_COLORS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input hpgc_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output hpgc_pkg::out_item_t out_item,
	input logic cfg_we,
	input logic [16:0] cfg_data
);

	// Groups beyond the fixed table do not exist.
	localparam int NUM_ACTIVE = (NUM_GROUPS > hpgc_pkg::TABLE_GROUPS)
		? hpgc_pkg::TABLE_GROUPS : NUM_GROUPS;

	logic [16:0] misc_threshold_q;
	hpgc_pkg::dp_cmd_t cmd;
	hpgc_pkg::dp_sts_t sts;

	// The one register: the threshold below which an image counts as miscellaneous.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) misc_threshold_q <= 17'd19661;
		else if (cfg_we) misc_threshold_q <= cfg_data;
	end

	hpgc_ctrl #(.NUM_ACTIVE(NUM_ACTIVE)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	hpgc_dp #(.NUM_ACTIVE(NUM_ACTIVE), .MAX_COLORS(MAX_COLORS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .misc_threshold(misc_threshold_q),
		.cmd(cmd), .sts(sts), .out_item(out_item)
	);

endmodule

// ===== rtl/core/hpgc_ctrl.sv =====
`include "hsv_palette_group_classifier_assert.svh"

module hpgc_ctrl #(
	parameter int NUM_ACTIVE = 12
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input hpgc_pkg::dp_sts_t sts,
	output hpgc_pkg::dp_cmd_t cmd
);

	localparam int GW = 4;
	localparam logic [GW-1:0] LAST_G = GW'(NUM_ACTIVE - 1);

	typedef enum logic [3:0] {
		IDLE, SCORE, NORM, ACCUM, DSTART, DSTEP, PICK, FINISH, OUTW
	} state_t;

	state_t state_q;
	logic [GW-1:0] grp_q;
	logic in_acc;

	assign in_acc = in_valid && in_ready;
	assign in_ready = (state_q == IDLE) || (state_q == OUTW && out_ready);
	assign out_valid = (state_q == OUTW);

	always_comb begin
		cmd = '0;
		cmd.load = in_acc;
		cmd.score = (state_q == SCORE);
		cmd.norm = (state_q == NORM);
		cmd.accum = (state_q == ACCUM);
		cmd.div_start = (state_q == DSTART);
		cmd.div_step = (state_q == DSTEP);
		cmd.pick = (state_q == PICK);
		cmd.finish = (state_q == FINISH);
		cmd.grp = grp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			grp_q <= '0;
		end else begin
			case (state_q)
				IDLE, OUTW: begin
					if (in_acc) state_q <= SCORE;
					else if (state_q == OUTW && out_ready) state_q <= IDLE;
				end
				SCORE: state_q <= sts.counted ? NORM : (sts.last ? DSTART : IDLE);
				NORM: state_q <= ACCUM;
				ACCUM: state_q <= sts.last ? DSTART : IDLE;
				DSTART: state_q <= DSTEP;
				DSTEP: if (sts.div_done) state_q <= PICK;
				PICK: begin
					if (grp_q == LAST_G) begin
						grp_q <= '0;
						state_q <= FINISH;
					end else begin
						grp_q <= grp_q + 1'b1;
						state_q <= DSTART;
					end
				end
				FINISH: state_q <= OUTW;
				default: state_q <= IDLE;
			endcase
		end
	end

	`HPGC_ASSERT_IMPL(a_out_no_in, clk, arst_n, out_valid && !out_ready, !in_ready)
	`HPGC_ASSERT_NEXT(a_finish_out, clk, arst_n, cmd.finish, out_valid)
	`HPGC_ASSERT_IMPL(a_grp_range, clk, arst_n, 1'b1, grp_q <= LAST_G)

endmodule

// ===== rtl/core/hpgc_dp.sv =====
module hpgc_dp #(
	parameter int NUM_ACTIVE = 12,
	parameter int MAX_COLORS = 8
) (
	input logic clk,
	input logic arst_n,
	input hpgc_pkg::in_item_t in_item,
	input logic [16:0] misc_threshold,
	input hpgc_pkg::dp_cmd_t cmd,
	output hpgc_pkg::dp_sts_t sts,
	output hpgc_pkg::out_item_t out_item
);

	localparam int CW = $clog2(MAX_COLORS + 1);
	localparam int NG = NUM_ACTIVE;

	hpgc_pkg::in_item_t item_q;
	logic [CW-1:0] ccount_q;
	logic [18:0] num_q [NG];
	logic [16:0] cscore_q [NG];
	logic [23:0] sums_q [NG];
	logic [19:0] wtot_q;
	logic [15:0] counts_q [NG+1];
	logic [19:0] rem_q;
	logic [15:0] quo_q;
	logic ovf_q;
	logic [4:0] bit_q;
	logic [16:0] best_q;
	logic [3:0] bidx_q;
	hpgc_pkg::out_item_t out_q;

	// Per-group score numerator over 459000; a full match gives the whole denominator.
	function automatic logic [18:0] score_num(input hpgc_pkg::hsv_range_t r,
			input logic [11:0] h, input logic [7:0] s, input logic [7:0] v);
		logic wrap, hin;
		logic [14:0] sx, vx, slo, shi, vlo, vhi, sd, vd;
		logic [12:0] d0, d1, d2, d3, hd;
		logic [22:0] nsub;
		wrap = r.hlo > r.hhi;
		hin = wrap ? (h >= r.hlo || h <= r.hhi) : (h >= r.hlo && h <= r.hhi);
		sx = 15'(s) * 15'd100;
		vx = 15'(v) * 15'd100;
		slo = 15'(r.slo) * 15'd255;
		shi = 15'(r.shi) * 15'd255;
		vlo = 15'(r.vlo) * 15'd255;
		vhi = 15'(r.vhi) * 15'd255;
		sd = (sx < slo) ? slo - sx : ((sx > shi) ? sx - shi : '0);
		vd = (vx < vlo) ? vlo - vx : ((vx > vhi) ? vx - vhi : '0);
		d0 = (h >= r.hlo) ? 13'(h - r.hlo) : 13'(r.hlo - h);
		d1 = (h >= r.hhi) ? 13'(h - r.hhi) : 13'(r.hhi - h);
		hd = (d0 < d1) ? d0 : d1;
		if (wrap) begin
			d2 = 13'(h) + 13'd3600 - 13'(r.hlo);
			d3 = (13'(h) >= 13'(r.hhi) + 13'd3600) ? 13'(h) - 13'(r.hhi) - 13'd3600
				: 13'(r.hhi) + 13'd3600 - 13'(h);
			if (d2 < hd) hd = d2;
			if (d3 < hd) hd = d3;
		end
		nsub = 23'(hd) * 23'd85 + 23'd6 * (23'(sd) + 23'(vd));
		if (hin && sd == '0 && vd == '0) return 19'(hpgc_pkg::SCORE_DEN);
		if (nsub >= 23'(hpgc_pkg::SCORE_DEN)) return '0;
		return 19'(23'(hpgc_pkg::SCORE_DEN) - nsub);
	endfunction

	assign sts.last = item_q.last_color;
	assign sts.counted = (ccount_q < CW'(MAX_COLORS));
	assign sts.div_done = (bit_q == 5'd0);
	assign out_item = out_q;

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_item;
		if (cmd.score) begin
			for (int g = 0; g < NG; g++) begin
				num_q[g] <= score_num(hpgc_pkg::range_of(4'(g)), item_q.hue_tenths,
					item_q.saturation, item_q.brightness);
			end
		end
		if (cmd.norm) begin
			for (int g = 0; g < NG; g++) begin
				cscore_q[g] <= 17'((52'(num_q[g]) * 52'(hpgc_pkg::SCORE_RECIP))
					>> hpgc_pkg::SCORE_SHIFT);
			end
		end
		if (cmd.div_start) begin
			// A sum at or above the total weight gives a score of one.
			ovf_q <= (sums_q[cmd.grp] >= 24'(wtot_q));
			rem_q <= sums_q[cmd.grp][19:0];
			quo_q <= '0;
			bit_q <= 5'd16;
		end else if (cmd.div_step && bit_q != 5'd0) begin
			// Restoring division of sum<<16 by the total weight, one bit a cycle.
			if ({rem_q, 1'b0} >= 21'(wtot_q)) begin
				rem_q <= 20'({rem_q, 1'b0} - 21'(wtot_q));
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[18:0], 1'b0};
				quo_q <= {quo_q[14:0], 1'b0};
			end
			bit_q <= bit_q - 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ccount_q <= '0;
			wtot_q <= '0;
			best_q <= '0;
			bidx_q <= '0;
			out_q <= '0;
			for (int g = 0; g < NG; g++) sums_q[g] <= '0;
			for (int g = 0; g <= NG; g++) counts_q[g] <= '0;
		end else begin
			if (cmd.accum) begin
				for (int g = 0; g < NG; g++) begin
					logic [33:0] p;
					logic [24:0] sm;
					p = 34'(cscore_q[g]) * 34'(item_q.weight);
					sm = 25'(sums_q[g]) + 25'(p[33:16]);
					sums_q[g] <= sm[24] ? hpgc_pkg::SUM_MAX : sm[23:0];
				end
				wtot_q <= ((21'(wtot_q) + 21'(item_q.weight)) > 21'(hpgc_pkg::WT_MAX))
					? hpgc_pkg::WT_MAX : 20'(wtot_q + 20'(item_q.weight));
				ccount_q <= ccount_q + 1'b1;
			end
			if (cmd.pick) begin
				logic [16:0] sc;
				sc = '0;
				if (wtot_q != '0)
					sc = ovf_q ? hpgc_pkg::ONE_Q16 : {1'b0, quo_q};
				if (sc > best_q) begin
					best_q <= sc;
					bidx_q <= cmd.grp + 4'd1;
				end
			end
			if (cmd.finish) begin
				logic [3:0] idx;
				logic [15:0] c;
				idx = (best_q < misc_threshold) ? hpgc_pkg::MISC_GROUP : bidx_q;
				c = counts_q[idx];
				if (c != hpgc_pkg::CNT_MAX) c = c + 16'd1;
				counts_q[idx] <= c;
				out_q <= '{idx, best_q, c};
				best_q <= '0;
				bidx_q <= '0;
				wtot_q <= '0;
				ccount_q <= '0;
				for (int g = 0; g < NG; g++) sums_q[g] <= '0;
			end
		end
	end

endmodule
